[sv/gbvt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the gyroid band voxel test.
package gbvt_pkg;

    localparam int FREQ_W    = 12;
    localparam int FREQ_FRAC = 8;
    localparam int IDX_W     = 8;
    localparam int LEVEL_W   = 15;
    localparam int THICK_W   = 14;
    localparam int VALUE_W   = 15;
    localparam int ROM_W     = 13;
    localparam int TRIG_W    = 14;
    localparam int PROD_W    = 27;
    localparam int SUM_W     = 28;
    localparam int FRAC_W    = 12;
    localparam int CMP_W     = 18;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam int STAGES  = 7;
    localparam int ST_PH0  = 0;
    localparam int ST_PH1  = 1;
    localparam int ST_PH2  = 2;
    localparam int ST_TRIG = 3;
    localparam int ST_MUL  = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_OUT  = 6;

    localparam logic [FREQ_W-1:0]         FREQ_RESET  = 12'd256;
    localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = 15'sd0;
    localparam logic [THICK_W-1:0]        THICK_RESET = 14'd2048;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FREQ_X,
        REG_FREQ_Y,
        REG_FREQ_Z,
        REG_LEVEL,
        REG_THICKNESS
    } t_reg_idx;

    typedef struct packed {
        logic [FREQ_W-1:0]         freq_x;
        logic [FREQ_W-1:0]         freq_y;
        logic [FREQ_W-1:0]         freq_z;
        logic signed [LEVEL_W-1:0] level;
        logic [THICK_W-1:0]        thickness;
    } t_cfg;

    typedef struct packed {
        logic [STAGES-1:0] adv;
    } t_pipe_ctl;

endpackage

[sv/gbvt_in_if.sv]
`timescale 1ns / 1ps
// Voxel index channel: valid, ready and one grid index triple per word.
interface gbvt_in_if;
    import gbvt_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] grid_x;
    logic [IDX_W-1:0] grid_y;
    logic [IDX_W-1:0] grid_z;

    modport source (output valid, output grid_x, output grid_y, output grid_z, input ready);
    modport sink (input valid, input grid_x, input grid_y, input grid_z, output ready);
endinterface

[sv/gbvt_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid, ready, band flag and surface value per word.
interface gbvt_out_if;
    import gbvt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      inside_res;
    logic signed [VALUE_W-1:0] surface_value;

    modport source (output valid, output inside_res, output surface_value, input ready);
    modport sink (input valid, input inside_res, input surface_value, output ready);
endinterface

[sv/gbvt_cfg.sv]
`timescale 1ns / 1ps
// APB register bank: axis frequencies, band level and thickness.
module gbvt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbvt_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbvt_pkg::PDATA_W-1:0]  pwdata,
    output logic [gbvt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output gbvt_pkg::t_cfg                o_cfg
);
    import gbvt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_x    <= FREQ_RESET;
            r_cfg.freq_y    <= FREQ_RESET;
            r_cfg.freq_z    <= FREQ_RESET;
            r_cfg.level     <= LEVEL_RESET;
            r_cfg.thickness <= THICK_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_FREQ_X:    r_cfg.freq_x    <= pwdata[FREQ_W-1:0];
                REG_FREQ_Y:    r_cfg.freq_y    <= pwdata[FREQ_W-1:0];
                REG_FREQ_Z:    r_cfg.freq_z    <= pwdata[FREQ_W-1:0];
                REG_LEVEL:     r_cfg.level     <= signed'(pwdata[LEVEL_W-1:0]);
                REG_THICKNESS: r_cfg.thickness <= pwdata[THICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FREQ_X:    prdata = PDATA_W'(r_cfg.freq_x);
            REG_FREQ_Y:    prdata = PDATA_W'(r_cfg.freq_y);
            REG_FREQ_Z:    prdata = PDATA_W'(r_cfg.freq_z);
            REG_LEVEL:     prdata = PDATA_W'(unsigned'(r_cfg.level));
            REG_THICKNESS: prdata = PDATA_W'(r_cfg.thickness);
            default:       prdata = '0;
        endcase
    end

endmodule

[sv/gbvt_phase.sv]
`timescale 1ns / 1ps
// Three-stage phase unit: freq * index / (256 * grid) in turns, by reciprocal.
module gbvt_phase #(
    parameter int GRID_SIZE  = 256,
    parameter int PHASE_BITS = 10
) (
    input  logic                         i_clk,
    input  gbvt_pkg::t_pipe_ctl          i_ctl,
    input  logic [gbvt_pkg::FREQ_W-1:0]  i_freq,
    input  logic [gbvt_pkg::IDX_W-1:0]   i_idx,
    output logic [PHASE_BITS-1:0]        o_phase
);
    import gbvt_pkg::*;

    localparam int PW          = FREQ_W + IDX_W;
    localparam int MW          = PW + PHASE_BITS - FREQ_FRAC;
    localparam int RECIP_SHIFT = 32;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(GRID_SIZE);
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_FULL[RECIP_SHIFT-1:0];

    logic [PW-1:0]             w_prod;
    logic [PW+PHASE_BITS-1:0]  w_prod_ext;
    logic [MW+RECIP_SHIFT-1:0] w_prod2;
    logic [MW-1:0]             w_qg;
    logic [MW-1:0]             w_rem;
    logic                      w_ge;

    logic [MW-1:0]             r_m;
    logic [MW-1:0]             r_m2;
    logic [MW-1:0]             r_q0;
    logic [PHASE_BITS-1:0]     r_phase;

    assign w_prod     = PW'(i_freq) * PW'(i_idx);
    assign w_prod_ext = {w_prod, {PHASE_BITS{1'b0}}};
    assign w_prod2    = (MW+RECIP_SHIFT)'(r_m) * (MW+RECIP_SHIFT)'(RECIP);
    assign w_qg       = r_q0 * MW'(GRID_SIZE);
    assign w_rem      = r_m2 - w_qg;
    assign w_ge       = (w_rem >= MW'(GRID_SIZE));
    assign o_phase    = r_phase;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_PH0]) begin
            r_m <= w_prod_ext[PW+PHASE_BITS-1:FREQ_FRAC];
        end
        if (i_ctl.adv[ST_PH1]) begin
            r_m2 <= r_m;
            r_q0 <= w_prod2[MW+RECIP_SHIFT-1:RECIP_SHIFT];
        end
        if (i_ctl.adv[ST_PH2]) begin
            r_phase <= r_q0[PHASE_BITS-1:0] + PHASE_BITS'(w_ge);
        end
    end

endmodule

[sv/gbvt_trig.sv]
`timescale 1ns / 1ps
// Quarter-wave sine table stage: sine and cosine of one phase in Q1.12.
module gbvt_trig #(
    parameter int PHASE_BITS = 10
) (
    input  logic                                i_clk,
    input  gbvt_pkg::t_pipe_ctl                 i_ctl,
    input  logic [PHASE_BITS-1:0]               i_phase,
    output logic signed [gbvt_pkg::TRIG_W-1:0]  o_sin,
    output logic signed [gbvt_pkg::TRIG_W-1:0]  o_cos
);
    import gbvt_pkg::*;

    localparam int  QB      = PHASE_BITS - 2;
    localparam int  QTR_LEN = 1 << QB;
    localparam real STEP    = 1.5707963267948966 / real'(QTR_LEN);

    function automatic logic [ROM_W-1:0] rom_entry(input int k);
        real a;
        real v;
        int  e;
        a = STEP * real'(k);
        v = 4096.0 * $sin(a);
        e = $rtoi(v + 0.5);
        if (e > 4096) begin
            e = 4096;
        end
        return ROM_W'(e);
    endfunction

    logic [ROM_W-1:0]         w_rom [QTR_LEN+1];
    logic [PHASE_BITS-1:0]    w_cph;
    logic [PHASE_BITS-1:0]    w_ph [2];
    logic signed [TRIG_W-1:0] w_val [2];

    for (genvar k = 0; k <= QTR_LEN; k++) begin : g_rom
        assign w_rom[k] = rom_entry(k);
    end

    assign w_cph   = i_phase + PHASE_BITS'(QTR_LEN);
    assign w_ph[0] = i_phase;
    assign w_ph[1] = w_cph;

    for (genvar j = 0; j < 2; j++) begin : g_look
        logic [1:0]               w_quad;
        logic [QB:0]              w_addr;
        logic signed [TRIG_W-1:0] w_mag;
        assign w_quad = w_ph[j][PHASE_BITS-1:PHASE_BITS-2];
        assign w_addr = w_quad[0] ? ((QB+1)'(QTR_LEN) - {1'b0, w_ph[j][QB-1:0]})
                                  : {1'b0, w_ph[j][QB-1:0]};
        assign w_mag  = signed'({1'b0, w_rom[w_addr]});
        assign w_val[j] = w_quad[1] ? -w_mag : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_TRIG]) begin
            o_sin <= w_val[0];
            o_cos <= w_val[1];
        end
    end

endmodule

[sv/gbvt_eval.sv]
`timescale 1ns / 1ps
// Surface sum, rounding to Q2.12 and strict band test over three stages.
module gbvt_eval (
    input  logic                                 i_clk,
    input  gbvt_pkg::t_pipe_ctl                  i_ctl,
    input  gbvt_pkg::t_cfg                       i_cfg,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_sx,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_cx,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_sy,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_cy,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_sz,
    input  logic signed [gbvt_pkg::TRIG_W-1:0]   i_cz,
    output logic                                 o_inside,
    output logic signed [gbvt_pkg::VALUE_W-1:0]  o_value
);
    import gbvt_pkg::*;

    logic signed [PROD_W-1:0]  r_p0;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic signed [VALUE_W-1:0] r_f;
    logic                      r_inside;
    logic signed [VALUE_W-1:0] r_value;

    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_rnd;
    logic signed [CMP_W-1:0]   w_two_f;
    logic signed [CMP_W-1:0]   w_lvl2;
    logic signed [CMP_W-1:0]   w_thk;
    logic signed [CMP_W-1:0]   w_low;
    logic signed [CMP_W-1:0]   w_high;

    assign w_sum   = SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2);
    assign w_rnd   = w_sum + SUM_W'(2048);
    assign w_two_f = CMP_W'(signed'({r_f, 1'b0}));
    assign w_lvl2  = CMP_W'(signed'({i_cfg.level, 1'b0}));
    assign w_thk   = signed'(CMP_W'(i_cfg.thickness));
    assign w_low   = w_lvl2 - w_thk;
    assign w_high  = w_lvl2 + w_thk;

    assign o_inside = r_inside;
    assign o_value  = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_MUL]) begin
            r_p0 <= PROD_W'(i_sx * i_cy);
            r_p1 <= PROD_W'(i_sy * i_cz);
            r_p2 <= PROD_W'(i_sz * i_cx);
        end
        if (i_ctl.adv[ST_SUM]) begin
            // floor of (sum + half) / 4096
            r_f <= signed'(w_rnd[FRAC_W+VALUE_W-1:FRAC_W]);
        end
        if (i_ctl.adv[ST_OUT]) begin
            r_inside <= (w_two_f > w_low) && (w_two_f < w_high);
            r_value  <= r_f;
        end
    end

endmodule

[sv/gyroid_band_voxel_test.sv]
`timescale 1ns / 1ps
// Top level of the gyroid band voxel test: register bank and seven-stage pipeline.
// Throughput: one voxel per cycle; bubbles collapse, stages hold on a stalled output.
// Stages: three for the phase divide by reciprocal, one for the sine table,
// one for the products, one for the sum and rounding, one for the band test.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module gyroid_band_voxel_test #(
    parameter int GRID_SIZE  = 256,
    parameter int PHASE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gbvt_in_if.sink                       i_vox,
    gbvt_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbvt_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbvt_pkg::PDATA_W-1:0]  pwdata,
    output logic [gbvt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import gbvt_pkg::*;

    t_cfg                     w_cfg;
    t_pipe_ctl                w_ctl;
    logic [STAGES-1:0]        r_valid;
    logic [PHASE_BITS-1:0]    w_px;
    logic [PHASE_BITS-1:0]    w_py;
    logic [PHASE_BITS-1:0]    w_pz;
    logic signed [TRIG_W-1:0] w_sx;
    logic signed [TRIG_W-1:0] w_cx;
    logic signed [TRIG_W-1:0] w_sy;
    logic signed [TRIG_W-1:0] w_cy;
    logic signed [TRIG_W-1:0] w_sz;
    logic signed [TRIG_W-1:0] w_cz;

    gbvt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_ctl.adv[ST_OUT] = !r_valid[ST_OUT] || o_res.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_ctl.adv[k] = !r_valid[k] || w_ctl.adv[k+1];
        end
    end

    assign i_vox.ready = w_ctl.adv[ST_PH0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ctl.adv[ST_PH0]) begin
                r_valid[ST_PH0] <= i_vox.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_ctl.adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    gbvt_phase #(.GRID_SIZE(GRID_SIZE), .PHASE_BITS(PHASE_BITS)) u_phase_x (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_freq (w_cfg.freq_x),
        .i_idx (i_vox.grid_x), .o_phase (w_px)
    );

    gbvt_phase #(.GRID_SIZE(GRID_SIZE), .PHASE_BITS(PHASE_BITS)) u_phase_y (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_freq (w_cfg.freq_y),
        .i_idx (i_vox.grid_y), .o_phase (w_py)
    );

    gbvt_phase #(.GRID_SIZE(GRID_SIZE), .PHASE_BITS(PHASE_BITS)) u_phase_z (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_freq (w_cfg.freq_z),
        .i_idx (i_vox.grid_z), .o_phase (w_pz)
    );

    gbvt_trig #(.PHASE_BITS(PHASE_BITS)) u_trig_x (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_phase (w_px), .o_sin (w_sx), .o_cos (w_cx)
    );

    gbvt_trig #(.PHASE_BITS(PHASE_BITS)) u_trig_y (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_phase (w_py), .o_sin (w_sy), .o_cos (w_cy)
    );

    gbvt_trig #(.PHASE_BITS(PHASE_BITS)) u_trig_z (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_phase (w_pz), .o_sin (w_sz), .o_cos (w_cz)
    );

    gbvt_eval u_eval (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg),
        .i_sx     (w_sx),
        .i_cx     (w_cx),
        .i_sy     (w_sy),
        .i_cy     (w_cy),
        .i_sz     (w_sz),
        .i_cz     (w_cz),
        .o_inside (o_res.inside_res),
        .o_value  (o_res.surface_value)
    );

    assign o_res.valid = r_valid[ST_OUT];

    // input held off only when every stage is full and the output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vox.ready |-> (o_res.valid && !o_res.ready && (&r_valid)))
        else $error("input stalled while pipeline has room");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.surface_value <= 15'sd12288
                         && o_res.surface_value >= -15'sd12288))
        else $error("surface value out of range");

    a_empty_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && w_cfg.thickness == '0) |-> !o_res.inside_res)
        else $error("inside flag set for empty band");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vox.valid && i_vox.ready) |=> r_valid[ST_PH0])
        else $error("accepted word lost at first stage");

endmodule
